### hw/rtl/utf8_cyrillic_lowercase_core_defines.svh
// Assertion helpers shared by the RTL.
`ifndef UTF8_CYRILLIC_LOWERCASE_CORE_DEFINES_SVH
`define UTF8_CYRILLIC_LOWERCASE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define UCL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UCL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ucl_pkg.sv
package ucl_pkg;

    // Input word: one raw text byte.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_word_t;

    // Output word: one result.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last_of_run;
        logic       end_of_text;
    } out_word_t;

    // A run is every result caused by one input byte.
    localparam int RUN_MAX   = 4;
    localparam int RUN_IDX_W = $clog2(RUN_MAX);

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_IDX_W-1:0]    last_idx;
        logic                    has_byte;
        logic                    fin;
    } run_t;

    // Run queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Length of the open multibyte sequence.
    typedef enum logic [2:0] {
        SEQ_NONE  = 3'd0,
        SEQ_TWO   = 3'd2,
        SEQ_THREE = 3'd3,
        SEQ_FOUR  = 3'd4
    } seq_len_t;

    localparam int HELD_DEPTH = 3;

    // Byte classes
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] LEAD2_TAG = 8'hC0;
    localparam logic [7:0] LEAD3_TAG = 8'hE0;
    localparam logic [7:0] LEAD4_TAG = 8'hF0;
    localparam logic [7:0] MASK3     = 8'hE0;
    localparam logic [7:0] MASK4     = 8'hF0;
    localparam logic [7:0] MASK5     = 8'hF8;
    localparam logic [7:0] ASCII_A   = 8'h41;
    localparam logic [7:0] ASCII_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    // Two-byte code points
    localparam int         CP_W        = 11;
    localparam logic [CP_W-1:0] CP_IO       = 11'h401;
    localparam logic [CP_W-1:0] CP_IO_LOWER = 11'h451;
    localparam logic [CP_W-1:0] CP_A        = 11'h410;
    localparam logic [CP_W-1:0] CP_YA       = 11'h42F;

endpackage

### hw/rtl/ucl_front.sv
module ucl_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ucl_pkg::in_word_t  s_data,
    input  ucl_pkg::queue_stat_t q_stat,
    output logic               push,
    output ucl_pkg::run_t      push_run
);
    import ucl_pkg::*;

    logic [HELD_DEPTH-1:0][7:0] held_reg, held_next;
    seq_len_t                   seq_len_reg, seq_len_next;
    logic [1:0]                 held_cnt_reg, held_cnt_next;

    logic            accept;
    logic [7:0]      b;
    logic            fin;
    logic            is_lead2, is_lead3, is_lead4;
    logic            seq_done;
    logic [7:0]      lc;
    logic [CP_W-1:0] cp, cp_low;
    logic            run_valid;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.text_byte;
    assign fin     = s_data.final_byte;

    // Classify the incoming byte
    assign is_lead2 = (b & MASK3) == LEAD2_TAG;
    assign is_lead3 = (b & MASK4) == LEAD3_TAG;
    assign is_lead4 = (b & MASK5) == LEAD4_TAG;
    assign seq_done = ({1'b0, held_cnt_reg} + 3'd1) >= 3'(seq_len_reg);
    assign lc       = (b >= ASCII_A && b <= ASCII_Z) ? (b + CASE_OFS) : b;

    // Two-byte decode and Cyrillic fold; continuation tag ignored
    assign cp = {held_reg[0][4:0], b[5:0]};
    always_comb begin
        if (cp == CP_IO) begin
            cp_low = CP_IO_LOWER;
        end else if (cp >= CP_A && cp <= CP_YA) begin
            cp_low = cp + CP_W'(CASE_OFS);
        end else begin
            cp_low = cp;
        end
    end

    // Result run for this byte
    always_comb begin
        push_run          = '0;
        push_run.has_byte = 1'b1;
        push_run.fin      = fin;
        run_valid         = 1'b0;
        if (seq_len_reg == SEQ_NONE) begin
            if (!b[7]) begin
                push_run.bytes[0] = lc;
                run_valid         = 1'b1;
            end else if (is_lead2) begin
                push_run.bytes[0] = b;
                run_valid         = fin;
            end else if (!is_lead3 && !is_lead4) begin
                push_run.bytes[0] = b;
                run_valid         = 1'b1;
            end
        end else if (seq_done) begin
            run_valid = 1'b1;
            unique case (seq_len_reg)
                SEQ_TWO: begin
                    push_run.bytes[0] = LEAD2_TAG | {3'b000, cp_low[10:6]};
                    push_run.bytes[1] = CONT_TAG | {2'b00, cp_low[5:0]};
                    push_run.last_idx = RUN_IDX_W'(1);
                end
                SEQ_THREE: begin
                    push_run.bytes[0] = held_reg[0];
                    push_run.bytes[1] = held_reg[1];
                    push_run.bytes[2] = b;
                    push_run.last_idx = RUN_IDX_W'(2);
                end
                SEQ_FOUR: begin
                    push_run.bytes[0] = held_reg[0];
                    push_run.bytes[1] = held_reg[1];
                    push_run.bytes[2] = held_reg[2];
                    push_run.bytes[3] = b;
                    push_run.last_idx = RUN_IDX_W'(3);
                end
                default: begin
                    run_valid = 1'b0;
                end
            endcase
        end
        // Bare end marker when the final byte gave nothing
        if (fin && !run_valid) begin
            push_run          = '0;
            push_run.fin      = 1'b1;
            run_valid         = 1'b1;
        end
    end

    assign push = accept && run_valid;

    // Sequence state
    always_comb begin
        held_next     = held_reg;
        seq_len_next  = seq_len_reg;
        held_cnt_next = held_cnt_reg;
        if (accept) begin
            if (seq_len_reg == SEQ_NONE) begin
                if (!fin && (is_lead2 || is_lead3 || is_lead4)) begin
                    held_next[0]  = b;
                    held_cnt_next = 2'd1;
                    if (is_lead2) begin
                        seq_len_next = SEQ_TWO;
                    end else if (is_lead3) begin
                        seq_len_next = SEQ_THREE;
                    end else begin
                        seq_len_next = SEQ_FOUR;
                    end
                end
            end else if (seq_done) begin
                held_next     = '0;
                seq_len_next  = SEQ_NONE;
                held_cnt_next = 2'd0;
            end else begin
                unique case (held_cnt_reg)
                    2'd0:    held_next[0] = b;
                    2'd1:    held_next[1] = b;
                    2'd2:    held_next[2] = b;
                    default: held_next    = held_reg;
                endcase
                held_cnt_next = held_cnt_reg + 2'd1;
            end
            if (fin) begin
                held_next     = '0;
                seq_len_next  = SEQ_NONE;
                held_cnt_next = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= '0;
            seq_len_reg  <= SEQ_NONE;
            held_cnt_reg <= 2'd0;
        end else begin
            held_reg     <= held_next;
            seq_len_reg  <= seq_len_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

endmodule

### hw/rtl/ucl_queue.sv
`include "utf8_cyrillic_lowercase_core_defines.svh"

module ucl_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ucl_pkg::run_t        push_run,
    input  logic                 pop,
    output ucl_pkg::run_t        head_run,
    output ucl_pkg::queue_stat_t q_stat
);
    import ucl_pkg::*;

    run_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;
    assign head_run     = q_mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Run storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_run;
        end
    end

    `UCL_ASSERT_IMP(a_no_overflow, aclk, aresetn, push, !q_stat.full, "push into full run queue")
    `UCL_ASSERT_IMP(a_no_underflow, aclk, aresetn, pop, !q_stat.empty, "pop from empty run queue")
    `UCL_ASSERT_NXT(a_fill_up, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + QCNT_W'(1), "fill count did not advance on push")

endmodule

### hw/rtl/ucl_back.sv
`include "utf8_cyrillic_lowercase_core_defines.svh"

module ucl_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ucl_pkg::run_t        head_run,
    input  ucl_pkg::queue_stat_t q_stat,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ucl_pkg::out_word_t   m_data
);
    import ucl_pkg::*;

    logic [RUN_IDX_W-1:0] idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    out_word_t            m_data_reg, m_data_next;

    logic load;
    logic at_last;

    // Take the next byte of the head run whenever the output slot frees
    assign load    = !q_stat.empty && (!m_valid_reg || m_ready);
    assign at_last = idx_reg == head_run.last_idx;
    assign pop     = load && at_last;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            idx_next                 = at_last ? '0 : idx_reg + RUN_IDX_W'(1);
            m_valid_next             = 1'b1;
            m_data_next.out_byte     = head_run.bytes[idx_reg];
            m_data_next.has_byte     = head_run.has_byte;
            m_data_next.last_of_run  = at_last;
            m_data_next.end_of_text  = at_last && head_run.fin;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `UCL_ASSERT_IMP(a_end_is_last, aclk, aresetn, m_valid_reg && m_data_reg.end_of_text,
        m_data_reg.last_of_run, "end of text on a word that is not last of run")
    `UCL_ASSERT_IMP(a_bare_marker, aclk, aresetn, m_valid_reg && !m_data_reg.has_byte,
        m_data_reg.end_of_text && m_data_reg.out_byte == 8'h00, "malformed bare end marker")
    `UCL_ASSERT_NXT(a_idx_step, aclk, aresetn, load && !at_last,
        idx_reg == $past(idx_reg) + RUN_IDX_W'(1), "run index did not advance")

endmodule

### hw/rtl/utf8_cyrillic_lowercase_core.sv
// Streaming UTF-8 lower-caser: one text byte enters per cycle on s_* while the
// run queue has room; results leave one word per cycle on m_* while m_ready is
// high. ASCII A-Z and two-byte Cyrillic capitals (U+0401, U+0410..U+042F) are
// folded; longer sequences are held and released whole. A byte that causes one
// result sustains one byte per cycle unless m_ready stalls; a byte completing a
// sequence releases a run of two to four words, and the output port sets the
// rate then. A four-entry run queue between the byte classifier and the output
// sequencer absorbs these bursts and output stalls; input is refused only when
// it is full. Each result is written into the run queue and then registered
// onto m_*. The last word of each text carries end_of_text, and is a bare
// marker (has_byte low) when the final byte gives nothing else.
module utf8_cyrillic_lowercase_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ucl_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ucl_pkg::out_word_t  m_data
);
    import ucl_pkg::*;

    queue_stat_t q_stat;
    logic        push;
    logic        pop;
    run_t        push_run;
    run_t        head_run;

    ucl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_stat   (q_stat),
        .push     (push),
        .push_run (push_run)
    );

    ucl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head_run (head_run),
        .q_stat   (q_stat)
    );

    ucl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_run (head_run),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### bench/tb_utf8_cyrillic_lowercase_core.sv
module tb_utf8_cyrillic_lowercase_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ucl_pkg::*;

    localparam int STALL_LIMIT = 1000;  // cycles with no word moving on either side
    localparam int HOLD_CYCLES = 80;    // long receiver hold-off
    localparam int RANDOM_ITEMS = 300;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    utf8_cyrillic_lowercase_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Directed rows: input word, whether the single result is typed in, that result
    typedef struct packed {
        in_word_t  word;
        logic      typed;
        out_word_t want;
    } row_t;

    localparam int DIR_ROWS = 27;
    localparam row_t DIRECTED [DIR_ROWS] = '{
        '{'{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},  // lowest byte
        '{'{8'h41, 1'b0}, 1'b1, '{8'h61, 1'b1, 1'b1, 1'b0}},  // 'A'
        '{'{8'h5A, 1'b0}, 1'b1, '{8'h7A, 1'b1, 1'b1, 1'b0}},  // 'Z'
        '{'{8'h40, 1'b0}, 1'b1, '{8'h40, 1'b1, 1'b1, 1'b0}},  // just below 'A'
        '{'{8'h7F, 1'b0}, 1'b1, '{8'h7F, 1'b1, 1'b1, 1'b0}},  // top of ASCII
        '{'{8'h80, 1'b0}, 1'b1, '{8'h80, 1'b1, 1'b1, 1'b0}},  // stray continuation
        '{'{8'hFF, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},  // stray high byte
        '{'{8'hD0, 1'b0}, 1'b0, '0},                          // capital IO
        '{'{8'h81, 1'b0}, 1'b0, '0},
        '{'{8'hD0, 1'b0}, 1'b0, '0},                          // capital A
        '{'{8'h90, 1'b0}, 1'b0, '0},
        '{'{8'hD0, 1'b0}, 1'b0, '0},                          // capital YA
        '{'{8'hAF, 1'b0}, 1'b0, '0},
        '{'{8'hC3, 1'b0}, 1'b0, '0},                          // ASCII taken as continuation
        '{'{8'h41, 1'b0}, 1'b0, '0},
        '{'{8'hE2, 1'b0}, 1'b0, '0},                          // three-byte pass-through
        '{'{8'h82, 1'b0}, 1'b0, '0},
        '{'{8'hAC, 1'b0}, 1'b0, '0},
        '{'{8'hF0, 1'b0}, 1'b0, '0},                          // four-byte pass-through
        '{'{8'h9F, 1'b0}, 1'b0, '0},
        '{'{8'h98, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b0}, 1'b0, '0},
        '{'{8'hDF, 1'b1}, 1'b1, '{8'hDF, 1'b1, 1'b1, 1'b1}},  // lone two-byte lead at end
        '{'{8'hE2, 1'b0}, 1'b0, '0},                          // cut-off three-byte
        '{'{8'h82, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{'{8'hF4, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},  // four-byte lead alone at end
        '{'{8'hC0, 1'b0}, 1'b0, '0}
    };

    // Lower-casing state mirrored from the block
    logic [7:0] held [HELD_DEPTH];
    seq_len_t   seq_len;
    logic [1:0] held_cnt;

    out_word_t expected_words [$];
    in_word_t  text_q [$];
    int        bad_words = 0;
    int        idle_cycles;
    int        gap_pct;
    int        stall_pct;
    logic      hold_req;
    logic      hold_done;
    logic      calm;

    function automatic void clear_fold();
        int i;
        for (i = 0; i < HELD_DEPTH; i++) held[i] = 8'h00;
        seq_len  = SEQ_NONE;
        held_cnt = 2'd0;
    endfunction

    function automatic out_word_t text_word(input logic [7:0] value);
        return '{value, 1'b1, 1'b0, 1'b0};
    endfunction

    // Append to the expected result list
    function automatic void add_expected(input out_word_t w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    // Append one non-final byte to the text being built
    function automatic void add_text_byte(input logic [7:0] value);
        text_q.insert(text_q.size(), '{value, 1'b0});
    endfunction

    // Lower-case one text byte; returns the number of result words
    function automatic int fold_byte(input in_word_t w, output out_word_t run [RUN_MAX]);
        logic [7:0]      b;
        logic            fin;
        logic [CP_W-1:0] cp;
        int              n;
        int              i;
        b   = w.text_byte;
        fin = w.final_byte;
        n   = 0;
        for (i = 0; i < RUN_MAX; i++) run[i] = '0;
        if (seq_len == SEQ_NONE) begin
            if (!b[7]) begin
                run[n++] = text_word((b >= ASCII_A && b <= ASCII_Z) ? b + CASE_OFS : b);
            end else if ((b & MASK3) == LEAD2_TAG) begin
                if (fin) begin
                    run[n++] = text_word(b);
                end else begin
                    held[0] = b; held_cnt = 2'd1; seq_len = SEQ_TWO;
                end
            end else if ((b & MASK4) == LEAD3_TAG) begin
                if (!fin) begin
                    held[0] = b; held_cnt = 2'd1; seq_len = SEQ_THREE;
                end
            end else if ((b & MASK5) == LEAD4_TAG) begin
                if (!fin) begin
                    held[0] = b; held_cnt = 2'd1; seq_len = SEQ_FOUR;
                end
            end else begin
                run[n++] = text_word(b);
            end
        end else if (int'(held_cnt) + 1 >= int'(seq_len)) begin
            // sequence completes on this byte
            if (seq_len == SEQ_TWO) begin
                cp = {held[0][4:0], b[5:0]};
                if (cp == CP_IO) cp = CP_IO_LOWER;
                else if (cp >= CP_A && cp <= CP_YA) cp = cp + CP_W'(CASE_OFS);
                run[n++] = text_word({3'b110, cp[10:6]});
                run[n++] = text_word({2'b10, cp[5:0]});
            end else begin
                for (i = 0; i < int'(held_cnt); i++) run[n++] = text_word(held[i]);
                run[n++] = text_word(b);
            end
            clear_fold();
        end else begin
            if (held_cnt < 2'd3) held[held_cnt] = b;
            held_cnt = held_cnt + 2'd1;
            if (fin) clear_fold();
        end
        if (fin) begin
            if (n == 0) run[n++] = '0;
            run[n-1].end_of_text = 1'b1;
            clear_fold();
        end
        if (n > 0) run[n-1].last_of_run = 1'b1;
        return n;
    endfunction

    // Random continuation: mostly 10xxxxxx, sometimes any byte
    function automatic logic [7:0] rand_cont();
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    function automatic void note_mismatch(input string what, input out_word_t want,
                                          input out_word_t got);
        if (bad_words < 10)
            $display("%0t %s: expected %h/%b/%b/%b got %h/%b/%b/%b (byte/has/last/eot)",
                     $realtime, what, want.out_byte, want.has_byte, want.last_of_run,
                     want.end_of_text, got.out_byte, got.has_byte, got.last_of_run,
                     got.end_of_text);
        bad_words++;
    endfunction

    // Offer one word, wait for it to be taken, record what it should give, and sometimes leave a gap
    task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
        out_word_t run [RUN_MAX];
        int        n;
        int        i;
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n = fold_byte(w, run);
        if (typed) begin
            add_expected(want);
        end else begin
            for (i = 0; i < n; i++) add_expected(run[i]);
        end
        if (!(hold_req && !hold_done) && !calm && $urandom_range(1, 100) <= gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                note_mismatch("unexpected word", '0, m_data);
            end else if (m_data.out_byte    !== expected_words[0].out_byte ||
                         m_data.has_byte    !== expected_words[0].has_byte ||
                         m_data.last_of_run !== expected_words[0].last_of_run ||
                         m_data.end_of_text !== expected_words[0].end_of_text) begin
                note_mismatch("mismatch", expected_words.pop_front(), m_data);
            end else begin
                void'(expected_words.pop_front());
            end
        end
    end

    // Watchdog: no word moving on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("utf8_cyrillic_lowercase_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        hold_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Stimulus
    initial begin
        int       random_sent;
        int       n_chars;
        int       kind;
        int       cut;
        int       r;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        hold_req    = 1'b0;
        calm        = 1'b0;
        gap_pct     = 10;
        stall_pct   = 10;
        random_sent = 0;
        clear_fold();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (r = 0; r < DIR_ROWS; r++)
            send_word(DIRECTED[r].word, DIRECTED[r].typed, DIRECTED[r].want);
        send_word('{8'h80, 1'b1}, 1'b0, '0);

        // let the block drain completely before the random texts
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);

        // random texts built from well-formed characters with some noise
        while (random_sent < RANDOM_ITEMS) begin
            text_q.delete();
            n_chars   = $urandom_range(1, 8);
            gap_pct   = 20 * $urandom_range(0, 2);
            stall_pct = 20 * $urandom_range(0, 2);
            repeat (n_chars) begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1, 2: begin
                        if ($urandom_range(0, 1))
                            add_text_byte(8'($urandom_range(8'h40, 8'h5B)));
                        else
                            add_text_byte(8'($urandom_range(0, 8'h7F)));
                    end
                    3, 4, 5: begin
                        if ($urandom_range(0, 4) < 3) begin
                            add_text_byte(8'hD0);
                            add_text_byte(8'($urandom_range(8'h80, 8'hAF)));
                        end else begin
                            add_text_byte(8'($urandom_range(8'hC0, 8'hDF)));
                            add_text_byte(rand_cont());
                        end
                    end
                    6: begin
                        add_text_byte(8'($urandom_range(8'hE0, 8'hEF)));
                        repeat (2) add_text_byte(rand_cont());
                    end
                    7: begin
                        add_text_byte(8'($urandom_range(8'hF0, 8'hF7)));
                        repeat (3) add_text_byte(rand_cont());
                    end
                    8: begin
                        if ($urandom_range(0, 1))
                            add_text_byte(8'($urandom_range(8'h80, 8'hBF)));
                        else
                            add_text_byte(8'($urandom_range(8'hF8, 8'hFF)));
                    end
                    default: begin
                        add_text_byte(8'($urandom));
                    end
                endcase
            end
            // sometimes cut one or two bytes off the end of the text
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, 2);
                while (cut > 0 && text_q.size() > 1) begin
                    void'(text_q.pop_back());
                    cut--;
                end
            end
            text_q[text_q.size()-1].final_byte = 1'b1;
            foreach (text_q[k]) begin
                if (random_sent == 100) hold_req = 1'b1;
                if (random_sent >= RANDOM_ITEMS - 60) calm = 1'b1;
                send_word(text_q[k], 1'b0, '0);
                random_sent++;
            end
        end

        // drain and finish
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (bad_words == 0) begin
            $display("utf8_cyrillic_lowercase_core verification clean");
        end else begin
            $display("utf8_cyrillic_lowercase_core verification failed");
        end
        $finish;
    end

endmodule
